// ----- src/stack_delete_by_value_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stack delete-by-value unit
// Clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef STACK_DELETE_BY_VALUE_UNIT_MACROS_SVH
`define STACK_DELETE_BY_VALUE_UNIT_MACROS_SVH

// same-cycle implication
`define SDBV_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDBV_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sdbv_pkg.sv -----
// ---------------------------------------------------------------------------
// sdbv_pkg
// Shared codes, widths and types of the stack delete-by-value unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sdbv_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic                 busy;
    logic                 valid;
    logic [1:0]           status;
    logic                 pop_sel;
    logic [OUT_CNT_W-1:0] removed;
    logic [OUT_CNT_W-1:0] depth;
  } sdbv_stat_t;

endpackage

`default_nettype wire

// ----- src/sdbv_ram.sv -----
// ---------------------------------------------------------------------------
// sdbv_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sdbv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/sdbv_seq.sv -----
// ---------------------------------------------------------------------------
// sdbv_seq
// Stack sequencer: push/pop handling, scan and compaction over the entry
// RAM with one shared value comparator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stack_delete_by_value_unit_macros.svh"

module sdbv_seq #(
  parameter int unsigned STACK_DEPTH = sdbv_pkg::DEFAULT_STACK_DEPTH,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [sdbv_pkg::DATA_W-1:0] value_i,
  input  wire logic                        all_mode_i,
  input  wire logic [sdbv_pkg::DATA_W-1:0] rdata_i,
  output logic                             ram_we_o,
  output logic      [AW-1:0]               ram_waddr_o,
  output logic      [sdbv_pkg::DATA_W-1:0] ram_wdata_o,
  output logic                             ram_re_o,
  output logic      [AW-1:0]               ram_raddr_o,
  output sdbv_pkg::sdbv_stat_t             stat_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_MOVE
  } state_e;

  typedef struct packed {
    logic                           valid;
    logic [1:0]                     status;
    logic                           pop_sel;
    logic [sdbv_pkg::OUT_CNT_W-1:0] removed;
    logic [sdbv_pkg::OUT_CNT_W-1:0] depth;
  } res_t;

  state_e                      state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [CW-1:0]               wr_q, wr_d;
  logic [CW-1:0]               rem_q, rem_d;
  logic [AW-1:0]               pa_q, pa_d;
  logic                        pend_q, pend_d;
  logic                        drop_q, drop_d;
  logic [sdbv_pkg::DATA_W-1:0] val_q, val_d;
  res_t                        res_q, res_d;

  logic          eq;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] idx_dec;

  assign eq      = (rdata_i == val_q);
  assign top_idx = count_q - 1'b1;
  assign idx_dec = idx_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    rem_d       = rem_q;
    pa_d        = pa_q;
    pend_d      = pend_q;
    drop_d      = drop_q;
    val_d       = val_q;
    res_d       = res_q;
    res_d.valid = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_q[AW-1:0];
    ram_wdata_o = rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d.valid   = 1'b1;
          res_d.status  = sdbv_pkg::STATUS_OK;
          res_d.pop_sel = 1'b0;
          res_d.removed = '0;
          case (kind_i)
            sdbv_pkg::KIND_PUSH: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                res_d.status = sdbv_pkg::STATUS_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = count_q[AW-1:0];
                ram_wdata_o = value_i;
                count_d     = count_q + 1'b1;
              end
            end
            sdbv_pkg::KIND_POP: begin
              if (count_q == '0) begin
                res_d.status = sdbv_pkg::STATUS_EMPTY;
              end else begin
                ram_re_o      = 1'b1;
                ram_raddr_o   = top_idx[AW-1:0];
                count_d       = top_idx;
                res_d.pop_sel = 1'b1;
                res_d.removed = sdbv_pkg::OUT_CNT_W'(1);
              end
            end
            sdbv_pkg::KIND_DELETE: begin
              if (count_q == '0) begin
                res_d.status = sdbv_pkg::STATUS_EMPTY;
              end else begin
                res_d.valid = 1'b0;
                val_d       = value_i;
                rem_d       = '0;
                pend_d      = 1'b0;
                if (all_mode_i) begin
                  state_d = ST_MOVE;
                  drop_d  = 1'b1;
                  idx_d   = '0;
                  wr_d    = '0;
                end else begin
                  state_d = ST_FIND;
                  idx_d   = count_q;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        if (pend_q && eq) begin
          state_d = ST_MOVE;
          drop_d  = 1'b0;
          rem_d   = CW'(1);
          wr_d    = CW'(pa_q);
          idx_d   = CW'(pa_q) + 1'b1;
          pend_d  = 1'b0;
        end else if (idx_q != '0) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_dec[AW-1:0];
          idx_d       = idx_dec;
          pa_d        = idx_dec[AW-1:0];
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          state_d       = ST_IDLE;
          res_d.valid   = 1'b1;
          res_d.status  = sdbv_pkg::STATUS_NOTFOUND;
          res_d.pop_sel = 1'b0;
          res_d.removed = '0;
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_MOVE: begin
        if (idx_q != count_q) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (drop_q && eq) begin
            rem_d = rem_q + 1'b1;
          end else begin
            ram_we_o = 1'b1;
            wr_d     = wr_q + 1'b1;
          end
        end
        if (idx_q == count_q && !pend_q) begin
          state_d       = ST_IDLE;
          count_d       = wr_q;
          res_d.valid   = 1'b1;
          res_d.status  = (rem_q == '0) ? sdbv_pkg::STATUS_NOTFOUND : sdbv_pkg::STATUS_OK;
          res_d.pop_sel = 1'b0;
          res_d.removed = sdbv_pkg::OUT_CNT_W'(rem_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.depth = sdbv_pkg::OUT_CNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      rem_q   <= '0;
      pa_q    <= '0;
      pend_q  <= 1'b0;
      drop_q  <= 1'b0;
      val_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      rem_q   <= rem_d;
      pa_q    <= pa_d;
      pend_q  <= pend_d;
      drop_q  <= drop_d;
      val_q   <= val_d;
      res_q   <= res_d;
    end
  end

  assign stat_o.busy    = (state_q != ST_IDLE);
  assign stat_o.valid   = res_q.valid;
  assign stat_o.status  = res_q.status;
  assign stat_o.pop_sel = res_q.pop_sel;
  assign stat_o.removed = res_q.removed;
  assign stat_o.depth   = res_q.depth;

  `SDBV_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(STACK_DEPTH),
    "entry count exceeds stack depth")
  `SDBV_ASSERT_IMP(a_write_behind_read, clk_i, rst_ni, state_q == ST_MOVE, wr_q <= idx_q,
    "compaction write index passed read index")
  `SDBV_ASSERT_NXT(a_delete_goes_busy, clk_i, rst_ni,
    state_q == ST_IDLE && start_i && kind_i == sdbv_pkg::KIND_DELETE && count_q != '0,
    state_q != ST_IDLE && !res_q.valid, "delete did not start a scan")
  `SDBV_ASSERT_NXT(a_find_keeps_count, clk_i, rst_ni, state_q == ST_FIND, $stable(count_q),
    "entry count changed during search")

endmodule

`default_nettype wire

// ----- src/stack_delete_by_value_unit.sv -----
// ---------------------------------------------------------------------------
// stack_delete_by_value_unit
// Bounded LIFO stack of 32-bit values with push, pop and delete-by-value.
// ---------------------------------------------------------------------------
// Usage: raise start_i with kind_i and value_i; the beat is taken at a rising
// edge where start_i is high and busy_o is low. Each request gives one result
// beat on done_o for exactly one cycle, the cycle after the request finishes;
// the receiver cannot stall it and must take it then.
// Push and pop: result in the cycle after acceptance, busy_o stays low, so one
// request per cycle is sustained. Pop data comes from the registered RAM read.
// Delete on n entries: busy_o is high while the shared comparator walks the
// entry RAM, one entry per cycle through its single read port. Delete-all
// walks every entry and compacts the survivors; topmost-only scans down to
// the match at m, then moves the entries above it down; if none matches it
// reports not found. Delete on an empty stack answers without going busy.
// cfg_we_i/cfg_wdata_i write the delete mode (1 removes every match); write
// only while idle. Reset empties the stack and clears the mode to 0; entry
// storage is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module stack_delete_by_value_unit #(
  parameter int unsigned STACK_DEPTH = sdbv_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       kind_i,
  input  wire logic [sdbv_pkg::DATA_W-1:0]      value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_wdata_i,
  output logic                                  done_o,
  output logic      [1:0]                       status_o,
  output logic      [sdbv_pkg::DATA_W-1:0]      popped_value_o,
  output logic      [sdbv_pkg::OUT_CNT_W-1:0]   removed_count_o,
  output logic      [sdbv_pkg::OUT_CNT_W-1:0]   depth_after_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic                        all_mode_q;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [sdbv_pkg::DATA_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [sdbv_pkg::DATA_W-1:0] ram_rdata;
  sdbv_pkg::sdbv_stat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      all_mode_q <= cfg_wdata_i;
    end
  end

  sdbv_ram #(
    .Width (sdbv_pkg::DATA_W),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sdbv_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i && !stat.busy),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .all_mode_i  (all_mode_q),
    .rdata_i     (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .stat_o      (stat)
  );

  assign busy_o          = stat.busy;
  assign done_o          = stat.valid;
  assign status_o        = stat.status;
  assign popped_value_o  = stat.pop_sel ? ram_rdata : '0;
  assign removed_count_o = stat.removed;
  assign depth_after_o   = stat.depth;

endmodule

`default_nettype wire
